@@ sv/dalt_pkg.sv @@
// ----------------------------------------------------------------------------
// dalt_pkg: shared types and constants for the dual-axis light tracker
// Widths, reset values, register indexes, step sizes and the structs passed
// between the top level and the step logic.
// ----------------------------------------------------------------------------
package dalt_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int THR_BITS        = 12;
    localparam int ANGLE_BITS      = 8;
    localparam int SUM_BITS        = ANGLE_BITS + 2;   // signed, holds angle +/- step
    localparam int COMPARE_BITS    = ANGLE_BITS + 1;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = THR_BITS;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_H_BIG    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_H_MID    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_V_BIG    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_V_MID    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_PULSE    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_H_MAX    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_V_MAX    = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_V_MIN    = 3'd7;

    // register reset values
    localparam logic [THR_BITS-1:0]   H_BIG_RST   = 12'd120;
    localparam logic [THR_BITS-1:0]   H_MID_RST   = 12'd100;
    localparam logic [THR_BITS-1:0]   V_BIG_RST   = 12'd200;
    localparam logic [THR_BITS-1:0]   V_MID_RST   = 12'd120;
    localparam logic [ANGLE_BITS-1:0] PULSE_RST   = 8'd45;
    localparam logic [ANGLE_BITS-1:0] H_MAX_RST   = 8'd180;
    localparam logic [ANGLE_BITS-1:0] V_MAX_RST   = 8'd140;
    localparam logic [ANGLE_BITS-1:0] V_MIN_RST   = 8'd2;
    localparam logic [ANGLE_BITS-1:0] ANGLE_RST   = 8'd90;
    localparam logic [ANGLE_BITS-1:0] H_MIN_ANGLE = 8'd0;

    // step sizes
    localparam logic [SUM_BITS-1:0] H_STEP_BIG = 10'd20;
    localparam logic [SUM_BITS-1:0] H_STEP_MID = 10'd5;
    localparam logic [SUM_BITS-1:0] V_STEP_BIG = 10'd5;
    localparam logic [SUM_BITS-1:0] V_STEP_MID = 10'd2;
    localparam logic [SUM_BITS-1:0] STEP_MIN   = 10'd1;

    typedef struct packed {
        logic [THR_BITS-1:0]   h_big_threshold;
        logic [THR_BITS-1:0]   h_mid_threshold;
        logic [THR_BITS-1:0]   v_big_threshold;
        logic [THR_BITS-1:0]   v_mid_threshold;
        logic [ANGLE_BITS-1:0] pulse_base;
        logic [ANGLE_BITS-1:0] h_max_angle;
        logic [ANGLE_BITS-1:0] v_max_angle;
        logic [ANGLE_BITS-1:0] v_min_angle;
    } cfg_t;

    typedef struct packed {
        logic [ANGLE_BITS-1:0]   h_angle_out;
        logic [ANGLE_BITS-1:0]   v_angle_out;
        logic [COMPARE_BITS-1:0] h_compare;
        logic [COMPARE_BITS-1:0] v_compare;
        logic                    held;
    } res_t;

endpackage

@@ sv/dalt_in_if.sv @@
// ----------------------------------------------------------------------------
// dalt_in_if: sample set channel
// Valid/ready channel carrying one set of five light samples per request.
// ----------------------------------------------------------------------------
interface dalt_in_if #(
    parameter int SAMPLE_BITS = dalt_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] left_light;
    logic [SAMPLE_BITS-1:0] right_light;
    logic [SAMPLE_BITS-1:0] up_light;
    logic [SAMPLE_BITS-1:0] down_light;
    logic [SAMPLE_BITS-1:0] center_light;

    modport source (
        output valid, left_light, right_light, up_light, down_light, center_light,
        input  ready
    );

    modport sink (
        input  valid, left_light, right_light, up_light, down_light, center_light,
        output ready
    );
endinterface

@@ sv/dalt_out_if.sv @@
// ----------------------------------------------------------------------------
// dalt_out_if: angle result channel
// Valid/ready channel carrying the angles and servo compare values.
// ----------------------------------------------------------------------------
interface dalt_out_if;
    import dalt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ANGLE_BITS-1:0]   h_angle_out;
    logic [ANGLE_BITS-1:0]   v_angle_out;
    logic [COMPARE_BITS-1:0] h_compare;
    logic [COMPARE_BITS-1:0] v_compare;
    logic                    held;

    modport source (
        output valid, h_angle_out, v_angle_out, h_compare, v_compare, held,
        input  ready
    );

    modport sink (
        input  valid, h_angle_out, v_angle_out, h_compare, v_compare, held,
        output ready
    );
endinterface

@@ sv/dalt_core.sv @@
// ----------------------------------------------------------------------------
// dalt_core: tracker step logic
// Hold test, step size selection, angle update with clamp, compare values.
// ----------------------------------------------------------------------------
module dalt_core #(
    parameter int SAMPLE_BITS = dalt_pkg::SAMPLE_BITS_DEF
) (
    input  logic [SAMPLE_BITS-1:0]          left_light,
    input  logic [SAMPLE_BITS-1:0]          right_light,
    input  logic [SAMPLE_BITS-1:0]          up_light,
    input  logic [SAMPLE_BITS-1:0]          down_light,
    input  logic [SAMPLE_BITS-1:0]          center_light,
    input  dalt_pkg::cfg_t                  cfg,
    input  logic [dalt_pkg::ANGLE_BITS-1:0] h_angle,
    input  logic [dalt_pkg::ANGLE_BITS-1:0] v_angle,
    output dalt_pkg::res_t                  res
);
    import dalt_pkg::*;

    localparam int CMP_BITS = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

    logic                       hold;
    logic [CMP_BITS-1:0]        h_diff;
    logic [CMP_BITS-1:0]        v_diff;
    logic [SUM_BITS-1:0]        h_step;
    logic [SUM_BITS-1:0]        v_step;
    logic signed [SUM_BITS-1:0] h_sum;
    logic signed [SUM_BITS-1:0] v_sum;
    logic [ANGLE_BITS-1:0]      h_new;
    logic [ANGLE_BITS-1:0]      v_new;

    assign hold = (center_light > left_light) && (center_light > right_light) &&
                  (center_light > up_light)   && (center_light > down_light);

    always_comb
    begin
        h_diff = (left_light > right_light)
               ? CMP_BITS'(left_light - right_light)
               : CMP_BITS'(right_light - left_light);
        v_diff = (up_light > down_light)
               ? CMP_BITS'(up_light - down_light)
               : CMP_BITS'(down_light - up_light);

        if (h_diff > CMP_BITS'(cfg.h_big_threshold))
            h_step = H_STEP_BIG;
        else if (h_diff > CMP_BITS'(cfg.h_mid_threshold))
            h_step = H_STEP_MID;
        else
            h_step = STEP_MIN;

        if (v_diff > CMP_BITS'(cfg.v_big_threshold))
            v_step = V_STEP_BIG;
        else if (v_diff > CMP_BITS'(cfg.v_mid_threshold))
            v_step = V_STEP_MID;
        else
            v_step = STEP_MIN;

        h_sum = signed'({2'b00, h_angle});
        v_sum = signed'({2'b00, v_angle});
        if (!hold)
        begin
            // left brighter turns positive, down brighter turns positive
            if (left_light > right_light)
                h_sum = h_sum + signed'(h_step);
            else if (left_light < right_light)
                h_sum = h_sum - signed'(h_step);
            if (up_light > down_light)
                v_sum = v_sum - signed'(v_step);
            else if (up_light < down_light)
                v_sum = v_sum + signed'(v_step);
        end

        // max is tested first; when the two cross, only a sum above max gives max
        if (h_sum > signed'({2'b00, cfg.h_max_angle}))
            h_new = cfg.h_max_angle;
        else if (h_sum < signed'({2'b00, H_MIN_ANGLE}))
            h_new = H_MIN_ANGLE;
        else
            h_new = h_sum[ANGLE_BITS-1:0];

        if (v_sum > signed'({2'b00, cfg.v_max_angle}))
            v_new = cfg.v_max_angle;
        else if (v_sum < signed'({2'b00, cfg.v_min_angle}))
            v_new = cfg.v_min_angle;
        else
            v_new = v_sum[ANGLE_BITS-1:0];

        res.h_angle_out = h_new;
        res.v_angle_out = v_new;
        res.h_compare   = {1'b0, cfg.pulse_base} + {1'b0, h_new};
        res.v_compare   = {1'b0, cfg.pulse_base} + {1'b0, v_new};
        res.held        = hold;
    end
endmodule

@@ sv/dual_axis_light_tracker_step.sv @@
// ----------------------------------------------------------------------------
// dual_axis_light_tracker_step: two-axis sun tracker step
// Takes five light samples per request, steps the pan/tilt angles toward the
// brighter side, clamps them and reports servo compare values.
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+-------------------------------------
//   in_ch    | in  | valid/ready          | left/right/up/down/center samples
//   out_ch   | out | valid/ready          | angles, compare values, held flag
//   cfg      | in  | cfg_we (no wait)     | cfg_index, cfg_data
//
// One request per cycle sustained while out_ch is ready. The samples land
// in an input register, then the step logic writes the angle state and the
// result register on the same edge. Reset sets the angles to 90 and the
// config registers to their defaults; both stages come up empty. A stalled
// output holds its result while the input stage still takes one more request.
// ----------------------------------------------------------------------------
module dual_axis_light_tracker_step #(
    parameter int SAMPLE_BITS = dalt_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [dalt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [dalt_pkg::CFG_DATA_BITS-1:0] cfg_data,
    dalt_in_if.sink                          in_ch,
    dalt_out_if.source                       out_ch
);
    import dalt_pkg::*;

    // configuration registers
    cfg_t                  cfg_reg;

    // angle state
    logic [ANGLE_BITS-1:0] h_angle_reg;
    logic [ANGLE_BITS-1:0] v_angle_reg;

    // input stage
    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] left_reg;
    logic [SAMPLE_BITS-1:0] right_reg;
    logic [SAMPLE_BITS-1:0] up_reg;
    logic [SAMPLE_BITS-1:0] down_reg;
    logic [SAMPLE_BITS-1:0] center_reg;

    // result stage
    logic                   res_valid_reg;
    res_t                   res_reg;
    res_t                   res_next;

    logic                   advance;
    logic                   in_take;

    // the input stage moves on when the result stage is empty or draining
    assign advance     = in_valid_reg && (!res_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;
    assign in_take     = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.h_big_threshold <= H_BIG_RST;
            cfg_reg.h_mid_threshold <= H_MID_RST;
            cfg_reg.v_big_threshold <= V_BIG_RST;
            cfg_reg.v_mid_threshold <= V_MID_RST;
            cfg_reg.pulse_base      <= PULSE_RST;
            cfg_reg.h_max_angle     <= H_MAX_RST;
            cfg_reg.v_max_angle     <= V_MAX_RST;
            cfg_reg.v_min_angle     <= V_MIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_H_BIG: cfg_reg.h_big_threshold <= cfg_data[THR_BITS-1:0];
                REG_H_MID: cfg_reg.h_mid_threshold <= cfg_data[THR_BITS-1:0];
                REG_V_BIG: cfg_reg.v_big_threshold <= cfg_data[THR_BITS-1:0];
                REG_V_MID: cfg_reg.v_mid_threshold <= cfg_data[THR_BITS-1:0];
                REG_PULSE: cfg_reg.pulse_base      <= cfg_data[ANGLE_BITS-1:0];
                REG_H_MAX: cfg_reg.h_max_angle     <= cfg_data[ANGLE_BITS-1:0];
                REG_V_MAX: cfg_reg.v_max_angle     <= cfg_data[ANGLE_BITS-1:0];
                REG_V_MIN: cfg_reg.v_min_angle     <= cfg_data[ANGLE_BITS-1:0];
                default:   cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    // sample registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            left_reg   <= in_ch.left_light;
            right_reg  <= in_ch.right_light;
            up_reg     <= in_ch.up_light;
            down_reg   <= in_ch.down_light;
            center_reg <= in_ch.center_light;
        end
    end

    dalt_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .left_light   (left_reg),
        .right_light  (right_reg),
        .up_light     (up_reg),
        .down_light   (down_reg),
        .center_light (center_reg),
        .cfg          (cfg_reg),
        .h_angle      (h_angle_reg),
        .v_angle      (v_angle_reg),
        .res          (res_next)
    );

    // angle state and result valid move together with the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_angle_reg   <= ANGLE_RST;
            v_angle_reg   <= ANGLE_RST;
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            h_angle_reg   <= res_next.h_angle_out;
            v_angle_reg   <= res_next.v_angle_out;
            res_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_ch.valid       = res_valid_reg;
    assign out_ch.h_angle_out = res_reg.h_angle_out;
    assign out_ch.v_angle_out = res_reg.v_angle_out;
    assign out_ch.h_compare   = res_reg.h_compare;
    assign out_ch.v_compare   = res_reg.v_compare;
    assign out_ch.held        = res_reg.held;

endmodule
